>>> rtl/core/alcs_pkg.sv
// ----------------------------------------------------------------------------
// alcs_pkg
// Shared widths, register map, reset values and saturation bounds of the alignment column scorer.
// ----------------------------------------------------------------------------
package alcs_pkg;

    // Fixed field widths
    localparam int SYM_W   = 8;
    localparam int SCORE_W = 6;
    localparam int TOTAL_W = 32;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    // Count memory covers every raw symbol code
    localparam int SYM_DEPTH = 1 << SYM_W;

    // Register map, index taken from paddr[3:2]
    localparam logic [1:0] REG_MATCH    = 2'd0;
    localparam logic [1:0] REG_MISMATCH = 2'd1;
    localparam logic [1:0] REG_GAP      = 2'd2;

    // Register reset values
    localparam logic signed [SCORE_W-1:0] MATCH_RST    = 6'sd0;
    localparam logic signed [SCORE_W-1:0] MISMATCH_RST = 6'sd1;
    localparam logic [SYM_W-1:0]          GAP_RST      = 8'd45;

    // Saturation bounds of the running totals
    localparam logic signed [TOTAL_W-1:0] TOTAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [TOTAL_W-1:0] TOTAL_MIN = 32'sh8000_0000;

endpackage

>>> rtl/core/alignment_column_scorer.sv
// ----------------------------------------------------------------------------
// alignment_column_scorer
// Sum-of-pairs and consensus scoring of an alignment fed one symbol per item.
// ----------------------------------------------------------------------------

// Takes one symbol item per clock cycle, sustained, as long as results are
// drained. Each symbol does one read-modify-write of its count in a 256-entry
// count memory; the read is registered at accept time and a same-address write
// from the item ahead is bypassed into it, which is what sets the one item per
// cycle figure. A closing item passes from the input register through the count
// stage, product stage and total stage into the output register. Per
// column seen bits live in flip-flops and clear in the cycle a column closes,
// so there is no clearing pass after reset. Items that do not close a column
// never wait on the output side; a closing item waits only if all three stages
// behind it are full and the output is stalled.
module alignment_column_scorer
    import alcs_pkg::*;
#(
    parameter int MAX_ROWS      = 64,
    parameter int ALPHABET_SIZE = 256
)
(
    input  logic                      clk,
    input  logic                      rst_n,

    // Configuration port
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ADDR_W-1:0]         paddr,
    input  logic [DATA_W-1:0]         pwdata,
    output logic [DATA_W-1:0]         prdata,
    output logic                      pready,

    // Symbol input channel
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [SYM_W-1:0]          symbol,
    input  logic                      end_of_column,
    input  logic                      end_of_alignment,

    // Column result channel
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [SYM_W-1:0]          consensus_symbol,
    output logic signed [TOTAL_W-1:0] pairs_total,
    output logic signed [TOTAL_W-1:0] consensus_total,
    output logic                      gap_column,
    output logic                      shape_error,
    output logic                      final_res
);

    // Derived widths
    localparam int ROW_W  = $clog2(MAX_ROWS + 1);
    localparam int PAIR_W = $clog2((MAX_ROWS * (MAX_ROWS - 1)) / 2 + 1);
    localparam int PROD_W = PAIR_W + SCORE_W + 1;
    localparam int SUM_W  = TOTAL_W + 2;

    localparam logic [ROW_W-1:0] ROW_LIMIT = ROW_W'(MAX_ROWS);
    localparam logic [SYM_W:0]   ALPHA_LIM = (SYM_W + 1)'(ALPHABET_SIZE);
    localparam logic [SYM_W-1:0] ALPHA_TOP = SYM_W'(ALPHABET_SIZE - 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [SCORE_W-1:0] match_reg;
    logic signed [SCORE_W-1:0] mismatch_reg;
    logic [SYM_W-1:0]          gap_reg;
    logic                      cfg_wr;

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    // Write the addressed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg    <= MATCH_RST;
            mismatch_reg <= MISMATCH_RST;
            gap_reg      <= GAP_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_MATCH:    match_reg    <= signed'(pwdata[SCORE_W-1:0]);
                REG_MISMATCH: mismatch_reg <= signed'(pwdata[SCORE_W-1:0]);
                REG_GAP:      gap_reg      <= pwdata[SYM_W-1:0];
                default:      ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        unique case (paddr[3:2])
            REG_MATCH:    prdata = DATA_W'(match_reg);
            REG_MISMATCH: prdata = DATA_W'(mismatch_reg);
            REG_GAP:      prdata = DATA_W'(gap_reg);
            default:      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline handshake
    // ------------------------------------------------------------------
    logic s1_v_reg;
    logic s2_v_reg;
    logic s3_v_reg;
    logic out_valid_reg;

    logic s1_eoc_reg;
    logic s1_eoa_reg;
    logic s1_close;
    logic s1_retire;
    logic s2_ready;
    logic s3_ready;
    logic out_load;
    logic in_acc;

    assign out_load  = !out_valid_reg || !out_stall;
    assign s3_ready  = !s3_v_reg || out_load;
    assign s2_ready  = !s2_v_reg || s3_ready;
    assign s1_close  = s1_eoc_reg || s1_eoa_reg;
    assign s1_retire = s1_v_reg && (!s1_close || s2_ready);
    assign in_stall  = s1_v_reg && !s1_retire;
    assign in_acc    = in_valid && !in_stall;

    // ------------------------------------------------------------------
    // Input register and count memory read
    // ------------------------------------------------------------------
    logic [SYM_W-1:0] s1_sym_reg;
    logic             s1_gap_reg;
    logic [ROW_W-1:0] rd_reg;
    logic [ROW_W-1:0] cnt_mem [SYM_DEPTH];

    logic             in_gap;
    logic [SYM_W-1:0] in_sym;

    // Gap test on the raw symbol, clip others to the alphabet
    assign in_gap = (symbol == gap_reg);
    assign in_sym = (!in_gap && ({1'b0, symbol} >= ALPHA_LIM)) ? ALPHA_TOP : symbol;

    // Column state
    logic [SYM_DEPTH-1:0] seen_reg;
    logic [ROW_W-1:0]     rows_reg;
    logic [ROW_W-1:0]     expected_reg;
    logic [ROW_W-1:0]     best_cnt_reg;
    logic [SYM_W-1:0]     best_sym_reg;
    logic [PAIR_W-1:0]    eq_reg;
    logic [PAIR_W-1:0]    pcnt_reg;
    logic                 err_reg;

    logic             over;
    logic             cnt_wr;
    logic [ROW_W-1:0] c_live;
    logic [ROW_W-1:0] c_inc;

    assign over   = (rows_reg >= ROW_LIMIT);
    assign cnt_wr = s1_retire && !over;
    assign c_live = seen_reg[s1_sym_reg] ? rd_reg : '0;
    assign c_inc  = c_live + ROW_W'(1);

    // Hold the item and fetch its count, bypassing the write of the item ahead
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_sym_reg <= in_sym;
            s1_gap_reg <= in_gap;
            s1_eoc_reg <= end_of_column;
            s1_eoa_reg <= end_of_alignment;
            if (cnt_wr && (s1_sym_reg == in_sym))
            begin
                rd_reg <= c_inc;
            end
            else
            begin
                rd_reg <= cnt_mem[in_sym];
            end
        end
        if (cnt_wr)
        begin
            cnt_mem[s1_sym_reg] <= c_inc;
        end
    end

    // Track the occupancy of the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else if (in_acc)
        begin
            s1_v_reg <= 1'b1;
        end
        else if (s1_retire)
        begin
            s1_v_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Per-item column update
    // ------------------------------------------------------------------
    logic [ROW_W-1:0]  rows_next;
    logic [ROW_W-1:0]  best_cnt_next;
    logic [SYM_W-1:0]  best_sym_next;
    logic [PAIR_W-1:0] eq_next;
    logic [PAIR_W-1:0] pcnt_next;
    logic              err_next;
    logic              gapcol_next;
    logic [ROW_W-1:0]  cmatch_next;

    always_comb
    begin
        rows_next     = rows_reg;
        best_cnt_next = best_cnt_reg;
        best_sym_next = best_sym_reg;
        eq_next       = eq_reg;
        pcnt_next     = pcnt_reg;
        err_next      = err_reg || over;
        if (!over)
        begin
            rows_next = rows_reg + ROW_W'(1);
            eq_next   = eq_reg + PAIR_W'(c_live);
            pcnt_next = pcnt_reg + PAIR_W'(rows_reg);
            if (!s1_gap_reg && (c_inc >= best_cnt_reg))
            begin
                best_cnt_next = c_inc;
                best_sym_next = s1_sym_reg;
            end
        end

        // Shape checks at column close
        if (s1_close)
        begin
            if (rows_next < ROW_W'(2))
            begin
                err_next = 1'b1;
            end
            if ((expected_reg != '0) && (expected_reg != rows_next))
            begin
                err_next = 1'b1;
            end
        end

        // Rows equal to the consensus; symbol zero stands in for an all-gap column
        gapcol_next = (best_cnt_next == '0);
        if (!gapcol_next)
        begin
            cmatch_next = best_cnt_next;
        end
        else if (gap_reg == '0)
        begin
            cmatch_next = rows_next;
        end
        else
        begin
            cmatch_next = '0;
        end
    end

    // Advance column state, clear its counts when the column closes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg     <= '0;
            rows_reg     <= '0;
            expected_reg <= '0;
            best_cnt_reg <= '0;
            best_sym_reg <= '0;
            eq_reg       <= '0;
            pcnt_reg     <= '0;
            err_reg      <= 1'b0;
        end
        else if (s1_retire)
        begin
            if (s1_close)
            begin
                seen_reg     <= '0;
                rows_reg     <= '0;
                best_cnt_reg <= '0;
                best_sym_reg <= '0;
                eq_reg       <= '0;
                pcnt_reg     <= '0;
                if (s1_eoa_reg)
                begin
                    expected_reg <= '0;
                    err_reg      <= 1'b0;
                end
                else
                begin
                    err_reg <= err_next;
                    if (expected_reg == '0)
                    begin
                        expected_reg <= rows_next;
                    end
                end
            end
            else
            begin
                if (!over)
                begin
                    seen_reg[s1_sym_reg] <= 1'b1;
                end
                rows_reg     <= rows_next;
                best_cnt_reg <= best_cnt_next;
                best_sym_reg <= best_sym_next;
                eq_reg       <= eq_next;
                pcnt_reg     <= pcnt_next;
                err_reg      <= err_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Column stage: counts of the closed column
    // ------------------------------------------------------------------
    logic [ROW_W-1:0]  s2_n_reg;
    logic [ROW_W-1:0]  s2_cm_reg;
    logic [PAIR_W-1:0] s2_eq_reg;
    logic [PAIR_W-1:0] s2_pairs_reg;
    logic [SYM_W-1:0]  s2_sym_reg;
    logic              s2_gapcol_reg;
    logic              s2_err_reg;
    logic              s2_eoa_reg;

    // Hold the closed column's counts
    always_ff @(posedge clk)
    begin
        if (s1_retire && s1_close)
        begin
            s2_n_reg      <= rows_next;
            s2_cm_reg     <= cmatch_next;
            s2_eq_reg     <= eq_next;
            s2_pairs_reg  <= pcnt_next;
            s2_sym_reg    <= gapcol_next ? '0 : best_sym_next;
            s2_gapcol_reg <= gapcol_next;
            s2_err_reg    <= err_next;
            s2_eoa_reg    <= s1_eoa_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_v_reg <= s1_retire && s1_close;
        end
    end

    // ------------------------------------------------------------------
    // Product stage: scale the pair counts by the scores
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0] match_x;
    logic signed [PROD_W-1:0] mismatch_x;
    logic signed [PROD_W-1:0] pe_x;
    logic signed [PROD_W-1:0] pn_x;
    logic signed [PROD_W-1:0] ce_x;
    logic signed [PROD_W-1:0] cn_x;

    assign match_x    = PROD_W'(match_reg);
    assign mismatch_x = PROD_W'(mismatch_reg);
    assign pe_x = signed'(PROD_W'(s2_eq_reg));
    assign pn_x = signed'(PROD_W'(s2_pairs_reg - s2_eq_reg));
    assign ce_x = signed'(PROD_W'(s2_cm_reg));
    assign cn_x = signed'(PROD_W'(s2_n_reg - s2_cm_reg));

    logic signed [PROD_W-1:0] s3_pe_reg;
    logic signed [PROD_W-1:0] s3_pn_reg;
    logic signed [PROD_W-1:0] s3_ce_reg;
    logic signed [PROD_W-1:0] s3_cn_reg;
    logic [SYM_W-1:0]         s3_sym_reg;
    logic                     s3_gapcol_reg;
    logic                     s3_err_reg;
    logic                     s3_eoa_reg;

    // Register the four score products
    always_ff @(posedge clk)
    begin
        if (s2_v_reg && s3_ready)
        begin
            s3_pe_reg     <= PROD_W'(pe_x * match_x);
            s3_pn_reg     <= PROD_W'(pn_x * mismatch_x);
            s3_ce_reg     <= PROD_W'(ce_x * match_x);
            s3_cn_reg     <= PROD_W'(cn_x * mismatch_x);
            s3_sym_reg    <= s2_sym_reg;
            s3_gapcol_reg <= s2_gapcol_reg;
            s3_err_reg    <= s2_err_reg;
            s3_eoa_reg    <= s2_eoa_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_v_reg <= 1'b0;
        end
        else if (s3_ready)
        begin
            s3_v_reg <= s2_v_reg;
        end
    end

    // ------------------------------------------------------------------
    // Total stage: accumulate with saturation into the output register
    // ------------------------------------------------------------------
    function automatic logic signed [TOTAL_W-1:0] clamp_total(
        input logic signed [SUM_W-1:0] v
    );
        logic signed [TOTAL_W-1:0] r;
        if (v > SUM_W'(TOTAL_MAX))
        begin
            r = TOTAL_MAX;
        end
        else if (v < SUM_W'(TOTAL_MIN))
        begin
            r = TOTAL_MIN;
        end
        else
        begin
            r = v[TOTAL_W-1:0];
        end
        return r;
    endfunction

    logic signed [TOTAL_W-1:0] pair_sum_reg;
    logic signed [TOTAL_W-1:0] cons_sum_reg;
    logic signed [TOTAL_W-1:0] pair_sum_next;
    logic signed [TOTAL_W-1:0] cons_sum_next;

    assign pair_sum_next = clamp_total(SUM_W'(pair_sum_reg) + SUM_W'(s3_pe_reg)
                                       + SUM_W'(s3_pn_reg));
    assign cons_sum_next = clamp_total(SUM_W'(cons_sum_reg) + SUM_W'(s3_ce_reg)
                                       + SUM_W'(s3_cn_reg));

    logic transfer;
    assign transfer = s3_v_reg && out_load;

    // Update the running totals, drop them after the last column
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_sum_reg <= '0;
            cons_sum_reg <= '0;
        end
        else if (transfer)
        begin
            pair_sum_reg <= s3_eoa_reg ? '0 : pair_sum_next;
            cons_sum_reg <= s3_eoa_reg ? '0 : cons_sum_next;
        end
    end

    // Load the result item
    always_ff @(posedge clk)
    begin
        if (transfer)
        begin
            consensus_symbol <= s3_sym_reg;
            pairs_total      <= pair_sum_next;
            consensus_total  <= cons_sum_next;
            gap_column       <= s3_gapcol_reg;
            shape_error      <= s3_err_reg;
            final_res        <= s3_eoa_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= s3_v_reg;
        end
    end

    assign out_valid = out_valid_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef NO_ASSERTIONS
    a_close_clears_rows: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_retire && s1_close) |=> (rows_reg == '0) && (seen_reg == '0))
        else $error("column state not cleared after close");

    a_best_within_rows: assert property (@(posedge clk) disable iff (!rst_n)
        (best_cnt_reg <= rows_reg) && (eq_reg <= pcnt_reg))
        else $error("column counts inconsistent");

    a_last_column_resets_totals: assert property (@(posedge clk) disable iff (!rst_n)
        (transfer && s3_eoa_reg) |=> (pair_sum_reg == '0) && (cons_sum_reg == '0))
        else $error("totals not cleared after last column");

    a_stall_only_on_close: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_close && s2_v_reg && s3_v_reg && out_valid_reg))
        else $error("input stalled without a full result path");
`endif

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the alignment column scorer. Streams alignments
// column by column (short directed columns for ties, all-gap columns, shape
// faults, overlong columns and extreme symbols, then random alignments under
// several score and gap settings), predicts every column result in a
// scoreboard and compares each field of each result in arrival order.
// ----------------------------------------------------------------------------
module tb;
    import alcs_pkg::*;

    localparam int ROW_LIMIT = 64;
    localparam logic [SYM_W-1:0] SYM_A    = 8'h41;
    localparam logic [SYM_W-1:0] SYM_C    = 8'h43;
    localparam logic [SYM_W-1:0] SYM_G    = 8'h47;
    localparam logic [SYM_W-1:0] SYM_T    = 8'h54;
    localparam logic [SYM_W-1:0] SYM_DASH = 8'h2D;

    typedef struct {
        logic [SYM_W-1:0]          consensus;
        logic signed [TOTAL_W-1:0] pairs;
        logic signed [TOTAL_W-1:0] agreement;
        logic                      gap_col;
        logic                      fault;
        logic                      last;
    } column_result_t;

    // Column scorer model and queue of expected column results
    class column_tally;
        logic signed [SCORE_W-1:0] match_val;
        logic signed [SCORE_W-1:0] mismatch_val;
        logic [SYM_W-1:0]          gap_code;
        logic [6:0]                sym_count [SYM_DEPTH];
        bit                        sym_seen [SYM_DEPTH];
        int                        rows;
        int                        rows_first;
        int                        best_count;
        logic [SYM_W-1:0]          best_sym;
        int                        equal_pairs;
        longint                    pair_run;
        longint                    agree_run;
        bit                        fault;
        column_result_t            pending_columns [$];
        int                        errors;

        function new();
            match_val    = MATCH_RST;
            mismatch_val = MISMATCH_RST;
            gap_code     = GAP_RST;
            clear_column();
            rows_first = 0;
            pair_run   = 0;
            agree_run  = 0;
            fault      = 0;
            errors     = 0;
        endfunction

        function void clear_column();
            foreach (sym_seen[i]) sym_seen[i] = 0;
            rows        = 0;
            best_count  = 0;
            best_sym    = '0;
            equal_pairs = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [DATA_W-1:0] value);
            case (idx)
                REG_MATCH:    match_val    = value[SCORE_W-1:0];
                REG_MISMATCH: mismatch_val = value[SCORE_W-1:0];
                REG_GAP:      gap_code     = value[SYM_W-1:0];
                default: ;
            endcase
        endfunction

        // Count of a symbol in the current column; stale entries read as zero
        function int live(logic [SYM_W-1:0] s);
            return sym_seen[s] ? int'(sym_count[s]) : 0;
        endfunction

        function longint clamp(longint v);
            if (v > longint'(TOTAL_MAX)) return longint'(TOTAL_MAX);
            if (v < longint'(TOTAL_MIN)) return longint'(TOTAL_MIN);
            return v;
        endfunction

        function void take_symbol(logic [SYM_W-1:0] s, logic eoc, logic eoa);
            int             c;
            longint         n;
            longint         pairs;
            longint         agree;
            longint         mv;
            longint         mmv;
            column_result_t r;

            // Count the row, drop rows past the limit
            if (rows >= ROW_LIMIT) begin
                fault = 1;
            end
            else begin
                c = live(s);
                equal_pairs += c;
                sym_count[s] = 7'(c + 1);
                sym_seen[s]  = 1;
                rows++;
                if (s != gap_code && c + 1 >= best_count) begin
                    best_count = c + 1;
                    best_sym   = s;
                end
            end
            if (!eoc && !eoa) return;

            // Close the column and advance both totals
            n     = rows;
            pairs = n * (n - 1) / 2;
            agree = live(best_sym);
            mv    = match_val;
            mmv   = mismatch_val;
            if (rows < 2) fault = 1;
            if (rows_first == 0) rows_first = rows;
            else if (rows_first != rows) fault = 1;
            pair_run  = clamp(pair_run + equal_pairs * mv + (pairs - equal_pairs) * mmv);
            agree_run = clamp(agree_run + agree * mv + (n - agree) * mmv);

            r.consensus = (best_count == 0) ? '0 : best_sym;
            r.pairs     = pair_run[TOTAL_W-1:0];
            r.agreement = agree_run[TOTAL_W-1:0];
            r.gap_col   = (best_count == 0);
            r.fault     = fault;
            r.last      = eoa;
            pending_columns.push_back(r);

            clear_column();
            if (eoa) begin
                rows_first = 0;
                pair_run   = 0;
                agree_run  = 0;
                fault      = 0;
            end
        endfunction

        function void flag(string field, logic signed [TOTAL_W:0] want_v,
                           logic signed [TOTAL_W:0] got_v);
            errors++;
            if (errors <= 40)
                $display("%0t: %s mismatch: expected %0d, got %0d",
                         $time, field, want_v, got_v);
        endfunction

        function void check_column(column_result_t got);
            column_result_t want;
            if (pending_columns.size() == 0) begin
                errors++;
                if (errors <= 40)
                    $display("%0t: unexpected column result: expected none, got consensus %0d",
                             $time, got.consensus);
                return;
            end
            want = pending_columns.pop_front();
            if (got.consensus !== want.consensus)
                flag("consensus_symbol", want.consensus, got.consensus);
            if (got.pairs !== want.pairs)
                flag("pairs_total", want.pairs, got.pairs);
            if (got.agreement !== want.agreement)
                flag("consensus_total", want.agreement, got.agreement);
            if (got.gap_col !== want.gap_col)
                flag("gap_column", want.gap_col, got.gap_col);
            if (got.fault !== want.fault)
                flag("shape_error", want.fault, got.fault);
            if (got.last !== want.last)
                flag("final_res", want.last, got.last);
        endfunction
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [ADDR_W-1:0]         paddr = '0;
    logic [DATA_W-1:0]         pwdata = '0;
    logic [DATA_W-1:0]         prdata;
    logic                      pready;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic [SYM_W-1:0]          symbol = '0;
    logic                      end_of_column = 1'b0;
    logic                      end_of_alignment = 1'b0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [SYM_W-1:0]          consensus_symbol;
    logic signed [TOTAL_W-1:0] pairs_total;
    logic signed [TOTAL_W-1:0] consensus_total;
    logic                      gap_column;
    logic                      shape_error;
    logic                      final_res;

    column_tally      tally = new();
    bit               steady = 1'b0;
    int               stall_left = 0;
    int               fed = 0;
    logic [SYM_W-1:0] gap_now = GAP_RST;

    alignment_column_scorer #(
        .MAX_ROWS      (ROW_LIMIT),
        .ALPHABET_SIZE (256)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .symbol           (symbol),
        .end_of_column    (end_of_column),
        .end_of_alignment (end_of_alignment),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .consensus_symbol (consensus_symbol),
        .pairs_total      (pairs_total),
        .consensus_total  (consensus_total),
        .gap_column       (gap_column),
        .shape_error      (shape_error),
        .final_res        (final_res)
    );

    // Clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Hard stop on a hung run
    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Idle length: mostly none or short, a few long
    function automatic int pick_idle();
        int r;
        if (steady) return 0;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(11, 30);
    endfunction

    // Stall the result channel in random bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
            stall_left--;
        else if (!steady && $urandom_range(3) == 0)
            stall_left = pick_idle();
        out_stall <= (stall_left > 0);
    end

    // Note each accepted item
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            tally.take_symbol(symbol, end_of_column, end_of_alignment);
    end

    // Check each accepted column result
    always @(posedge clk)
    begin : watch_results
        column_result_t got;
        if (rst_n && out_valid && !out_stall) begin
            got.consensus = consensus_symbol;
            got.pairs     = pairs_total;
            got.agreement = consensus_total;
            got.gap_col   = gap_column;
            got.fault     = shape_error;
            got.last      = final_res;
            tally.check_column(got);
        end
    end

    // Offer one item after a random gap and hold it until accepted
    task automatic push_symbol(logic [SYM_W-1:0] s, logic eoc, logic eoa);
        int idle;
        idle = pick_idle();
        if (idle != 0) begin
            in_valid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        in_valid         <= 1'b1;
        symbol           <= s;
        end_of_column    <= eoc;
        end_of_alignment <= eoa;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Drop valid and wait until every expected column has come back
    task automatic hold_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tally.pending_columns.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tally.set_reg(idx, value);
        @(posedge clk);
    endtask

    // Reprogram all registers once the pipeline is empty
    task automatic apply_config(int m, int mm, int g);
        hold_for_results();
        repeat (8) @(posedge clk);
        write_reg(REG_MATCH, DATA_W'(m));
        write_reg(REG_MISMATCH, DATA_W'(mm));
        write_reg(REG_GAP, DATA_W'(g));
        gap_now = g[SYM_W-1:0];
    endtask

    function automatic logic [SYM_W-1:0] pick_symbol(int style, logic [SYM_W-1:0] anchor);
        int r;
        r = $urandom_range(99);
        case (style)
            0: begin
                if (r < 20) return gap_now;
                case (r % 4)
                    0: return SYM_A;
                    1: return SYM_C;
                    2: return SYM_G;
                    default: return SYM_T;
                endcase
            end
            1: return 8'($urandom_range(255));
            2: begin
                if (r < 70) return anchor;
                if (r < 85) return gap_now;
                return 8'($urandom_range(255));
            end
            default: return gap_now;
        endcase
    endfunction

    // One alignment; a messy one bends row counts to raise shape faults
    task automatic send_alignment(bit messy);
        int               rows;
        int               cols;
        int               n;
        int               r;
        int               style;
        bit               last;
        bit               eoa_only;
        logic [SYM_W-1:0] anchor;
        r = $urandom_range(99);
        if (r < 80) rows = $urandom_range(2, 8);
        else if (r < 95) rows = $urandom_range(9, 20);
        else rows = $urandom_range(60, ROW_LIMIT);
        cols = (rows > 20) ? $urandom_range(1, 2) : $urandom_range(1, 6);
        for (int c = 0; c < cols; c++) begin
            n = rows;
            if (messy) begin
                r = $urandom_range(19);
                if (r == 0) n = $urandom_range(ROW_LIMIT + 1, ROW_LIMIT + 4);
                else if (r < 5) n = 1;
                else if (r < 9) n = rows + 1;
                else if (r < 12) n = (rows > 1) ? rows - 1 : 2;
            end
            r = $urandom_range(99);
            style  = (r < 40) ? 0 : (r < 65) ? 1 : (r < 95) ? 2 : 3;
            anchor = 8'($urandom_range(255));
            last     = (c == cols - 1);
            eoa_only = last && ($urandom_range(4) == 0);
            for (int i = 0; i < n; i++) begin
                push_symbol(pick_symbol(style, anchor),
                            (i == n - 1) && !eoa_only, last && (i == n - 1));
                if (i < ROW_LIMIT) fed++;
            end
        end
    endtask

    // Unstructured items with random end marks
    task automatic send_noise();
        int k;
        k = $urandom_range(1, 12);
        for (int i = 0; i < k; i++) begin
            push_symbol(8'($urandom_range(255)), $urandom_range(99) < 30,
                        $urandom_range(99) < 5);
            fed++;
        end
    endtask

    initial
    begin : stimulus
        int phase_end;
        int m;
        int mm;
        int g;
        int r;

        // Reset
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: ties, all-gap column, end of alignment without
        // end of column, single-row column, extreme codes and row mismatch
        push_symbol(SYM_A, 1'b0, 1'b0);
        push_symbol(SYM_A, 1'b0, 1'b0);
        push_symbol(SYM_DASH, 1'b1, 1'b0);
        push_symbol(SYM_DASH, 1'b0, 1'b0);
        push_symbol(SYM_DASH, 1'b0, 1'b0);
        push_symbol(SYM_DASH, 1'b1, 1'b0);
        push_symbol(SYM_C, 1'b0, 1'b0);
        push_symbol(SYM_G, 1'b0, 1'b0);
        push_symbol(SYM_T, 1'b0, 1'b1);
        push_symbol(SYM_A, 1'b1, 1'b1);
        push_symbol(8'h00, 1'b0, 1'b0);
        push_symbol(8'hFF, 1'b0, 1'b0);
        push_symbol(8'hFF, 1'b1, 1'b0);
        push_symbol(8'hFF, 1'b0, 1'b0);
        push_symbol(8'h00, 1'b1, 1'b0);
        push_symbol(8'hFF, 1'b0, 1'b0);
        push_symbol(8'h00, 1'b0, 1'b0);
        push_symbol(8'h00, 1'b1, 1'b1);

        // Gap code zero: a zero column counts every row toward the consensus
        apply_config(16, -16, 0);
        push_symbol(8'h00, 1'b0, 1'b0);
        push_symbol(8'h00, 1'b0, 1'b0);
        push_symbol(8'h00, 1'b1, 1'b0);
        push_symbol(8'h07, 1'b0, 1'b0);
        push_symbol(8'h07, 1'b0, 1'b0);
        push_symbol(8'h00, 1'b1, 1'b1);

        // Overlong column: rows past the limit are dropped
        apply_config(-16, 16, 255);
        for (int i = 0; i < ROW_LIMIT + 2; i++)
            push_symbol(8'($urandom_range(255)), i == ROW_LIMIT + 1, 1'b0);
        push_symbol(8'hFF, 1'b0, 1'b0);
        push_symbol(SYM_G, 1'b1, 1'b1);

        // Random phases under several settings, extremes first
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: begin m = 16;  mm = 16;  g = 45;  end
                1: begin m = -16; mm = -16; g = 0;   end
                2: begin m = 0;   mm = 1;   g = 45;  end
                default: begin
                    m  = int'($urandom_range(32)) - 16;
                    mm = int'($urandom_range(32)) - 16;
                    g  = ($urandom_range(1) == 0) ? 45 : $urandom_range(255);
                end
            endcase
            apply_config(m, mm, g);
            steady = (p == 2);
            phase_end = fed + 130;
            while (fed < phase_end) begin
                r = $urandom_range(99);
                if (r < 75) send_alignment(1'b0);
                else if (r < 90) send_alignment(1'b1);
                else send_noise();
                if ($urandom_range(19) == 0) hold_for_results();
            end
            send_alignment(1'b0);
        end
        steady = 1'b0;

        // Drain and report
        hold_for_results();
        repeat (20) @(posedge clk);
        if (tally.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> alignment_column_scorer.f
rtl/core/alcs_pkg.sv
rtl/core/alignment_column_scorer.sv
tb/sv/tb.sv
